[sv/ecd_pkg.sv]
// Constants and helper functions for the minutes-to-civil-date converter.
package ecd_pkg;

  localparam logic [21:0] DaysShift  = 22'd719468;
  localparam logic [17:0] EraDays    = 18'd146097;
  localparam logic [17:0] CentDays1  = 18'd36524;
  localparam logic [17:0] CentDays2  = 18'd73048;
  localparam logic [17:0] CentDays3  = 18'd109572;
  localparam logic [17:0] EraLastDay = 18'd146096;
  localparam logic [10:0] MinPerDay  = 11'd1440;
  localparam logic [10:0] MinPerHour = 11'd60;
  localparam logic [17:0] DaysPerYr  = 18'd365;
  localparam logic [13:0] YrsPerEra  = 14'd400;

  // floor(x / d) = (x * m) >> s, exact over the operand range used
  localparam logic [27:0] RecipDiv45   = 28'd190887436;  // s = 33, x < 2^27
  localparam logic [22:0] RecipEra     = 23'd7525902;    // s = 40, x < 2^22
  localparam logic [17:0] RecipDiv15   = 18'd547;        // s = 13, x < 2^9
  localparam logic [31:0] RecipDiv365a = 32'd91930;      // s = 25, x < 2^16
  localparam logic [36:0] RecipDiv365b = 37'd367720;     // s = 27, x < 2^18
  localparam logic [22:0] RecipDiv153  = 23'd3427;       // s = 19, x < 2^11

  // (153 * mp + 2) / 5: days before the month, March-based
  function automatic logic [8:0] month_offset(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] month_of(input logic [3:0] mp);
    return (mp < 4'd10) ? 4'(mp + 4'd3) : 4'(mp - 4'd9);
  endfunction

endpackage

[sv/epoch_minutes_to_civil_date.sv]
// Pipelined conversion of minutes since 1970-01-01 00:00 to civil date and time.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  input   | valid_i, stall_o, total_minutes_i              | in
//  output  | valid_o, stall_i, year_o, month_o, day_o,      | out
//          | hour_o, minute_o                               |
//
// Ten register stages, one transaction per cycle unless stalled; the
// last stage is the output register. Each stage holds narrow steps:
// reciprocal or constant multiplies, adds and compares. Reset clears
// only the valid bits. A stall freezes only the occupied stages at the
// tail; bubbles ahead of it keep filling, so nothing is dropped or repeated.
module epoch_minutes_to_civil_date
  import ecd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] total_minutes_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [13:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o
);

  localparam int unsigned NumStages = 10;

  logic [NumStages:1] v_q, v_d, en;

  always_comb begin
    en[NumStages] = !v_q[NumStages] || !stall_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[1] = en[1] ? valid_i : v_q[1];
    for (int k = 2; k <= NumStages; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign stall_o = !en[1];
  assign valid_o = v_q[NumStages];

  // stage 1: days = t / 1440
  logic [54:0] s1_prod;
  logic [21:0] s1_days_q;
  logic [31:0] s1_t_q;
  assign s1_prod = 55'(total_minutes_i[31:5]) * 55'(RecipDiv45);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_days_q <= s1_prod[54:33];
      s1_t_q    <= total_minutes_i;
    end
  end

  // stage 2: minute of day and shifted day number
  logic [21:0] s2_z_q;
  logic [10:0] s2_mod_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_z_q   <= s1_days_q + DaysShift;
      s2_mod_q <= s1_t_q[10:0] - 11'(s1_days_q * 22'(MinPerDay));
    end
  end

  // stage 3: era and hour
  logic [44:0] s3_era_prod;
  logic [17:0] s3_hour_prod;
  logic [4:0]  s3_era_q;
  logic [4:0]  s3_hour_q;
  logic [21:0] s3_z_q;
  logic [10:0] s3_mod_q;
  assign s3_era_prod  = 45'(s2_z_q) * 45'(RecipEra);
  assign s3_hour_prod = 18'(s2_mod_q[10:2]) * RecipDiv15;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_era_q  <= s3_era_prod[44:40];
      s3_hour_q <= s3_hour_prod[17:13];
      s3_z_q    <= s2_z_q;
      s3_mod_q  <= s2_mod_q;
    end
  end

  // stage 4: day of era and minute of hour
  logic [17:0] s4_doe_q;
  logic [4:0]  s4_era_q;
  logic [4:0]  s4_hour_q;
  logic [5:0]  s4_minute_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_doe_q    <= 18'(s3_z_q - 22'(22'(s3_era_q) * 22'(EraDays)));
      s4_era_q    <= s3_era_q;
      s4_hour_q   <= s3_hour_q;
      s4_minute_q <= 6'(s3_mod_q - 11'(11'(s3_hour_q) * MinPerHour));
    end
  end

  // stage 5: leap corrections of the day of era
  logic [31:0] s5_prod;
  logic [2:0]  s5_cent;
  logic [6:0]  s5_a_q;
  logic [2:0]  s5_b_q;
  logic        s5_c_q;
  logic [17:0] s5_doe_q;
  logic [4:0]  s5_era_q;
  logic [4:0]  s5_hour_q;
  logic [5:0]  s5_minute_q;
  assign s5_prod = 32'(s4_doe_q[17:2]) * RecipDiv365a;
  assign s5_cent = 3'(s4_doe_q >= CentDays1) + 3'(s4_doe_q >= CentDays2)
                 + 3'(s4_doe_q >= CentDays3) + 3'(s4_doe_q >= EraLastDay);

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_a_q      <= s5_prod[31:25];
      s5_b_q      <= s5_cent;
      s5_c_q      <= (s4_doe_q == EraLastDay);
      s5_doe_q    <= s4_doe_q;
      s5_era_q    <= s4_era_q;
      s5_hour_q   <= s4_hour_q;
      s5_minute_q <= s4_minute_q;
    end
  end

  // stage 6: numerator of year of era
  logic [17:0] s6_n_q;
  logic [17:0] s6_doe_q;
  logic [4:0]  s6_era_q;
  logic [4:0]  s6_hour_q;
  logic [5:0]  s6_minute_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_n_q      <= s5_doe_q - 18'(s5_a_q) + 18'(s5_b_q) - 18'(s5_c_q);
      s6_doe_q    <= s5_doe_q;
      s6_era_q    <= s5_era_q;
      s6_hour_q   <= s5_hour_q;
      s6_minute_q <= s5_minute_q;
    end
  end

  // stage 7: year of era
  logic [36:0] s7_prod;
  logic [8:0]  s7_yoe_q;
  logic [17:0] s7_doe_q;
  logic [4:0]  s7_era_q;
  logic [4:0]  s7_hour_q;
  logic [5:0]  s7_minute_q;
  assign s7_prod = 37'(s6_n_q) * RecipDiv365b;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_yoe_q    <= s7_prod[35:27];
      s7_doe_q    <= s6_doe_q;
      s7_era_q    <= s6_era_q;
      s7_hour_q   <= s6_hour_q;
      s7_minute_q <= s6_minute_q;
    end
  end

  // stage 8: day of year
  logic [1:0]  s8_cent;
  logic [8:0]  s8_doy_q;
  logic [8:0]  s8_yoe_q;
  logic [4:0]  s8_era_q;
  logic [4:0]  s8_hour_q;
  logic [5:0]  s8_minute_q;
  assign s8_cent = 2'(s7_yoe_q >= 9'd100) + 2'(s7_yoe_q >= 9'd200)
                 + 2'(s7_yoe_q >= 9'd300);

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_doy_q    <= 9'(s7_doe_q - (18'(s7_yoe_q) * DaysPerYr
                                    + 18'(s7_yoe_q[8:2]) - 18'(s8_cent)));
      s8_yoe_q    <= s7_yoe_q;
      s8_era_q    <= s7_era_q;
      s8_hour_q   <= s7_hour_q;
      s8_minute_q <= s7_minute_q;
    end
  end

  // stage 9: March-based month index
  logic [10:0] s9_num;
  logic [22:0] s9_prod;
  logic [3:0]  s9_mp_q;
  logic [8:0]  s9_doy_q;
  logic [8:0]  s9_yoe_q;
  logic [4:0]  s9_era_q;
  logic [4:0]  s9_hour_q;
  logic [5:0]  s9_minute_q;
  assign s9_num  = 11'(s8_doy_q) * 11'd5 + 11'd2;
  assign s9_prod = 23'(s9_num) * RecipDiv153;

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      s9_mp_q     <= s9_prod[22:19];
      s9_doy_q    <= s8_doy_q;
      s9_yoe_q    <= s8_yoe_q;
      s9_era_q    <= s8_era_q;
      s9_hour_q   <= s8_hour_q;
      s9_minute_q <= s8_minute_q;
    end
  end

  // stage 10: output register
  logic [3:0] s10_mo;
  assign s10_mo = month_of(s9_mp_q);

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      year_o   <= 14'(s9_yoe_q) + 14'(s9_era_q) * YrsPerEra + 14'(s10_mo <= 4'd2);
      month_o  <= s10_mo;
      day_o    <= 5'(s9_doy_q - month_offset(s9_mp_q) + 9'd1);
      hour_o   <= s9_hour_q;
      minute_o <= s9_minute_q;
    end
  end

endmodule
